>>> sv/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

>>> sv/sasd_pkg.sv
// Types, constants and the arctangent table of the scan arc segment detector.
// No dependencies.
package sasd_pkg;

   localparam int MAX_SAMPLES_DEF = 4096;
   localparam int TRIG_STEPS_DEF  = 16;

   localparam int CFG_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int RANGE_W    = 16;
   localparam int MUL_W      = 16;
   localparam int COORD_W    = 18;
   localparam int SQ_W       = COORD_W + 1;
   localparam int SQ_ACC_W   = 2 * SQ_W;
   localparam int X_W        = 36;
   localparam int Z_W        = 32;
   localparam int FRAC_BITS  = 16;
   localparam int ATAN_IDX_W = 5;
   localparam int PTS_W      = 3;
   localparam int LANES      = 4;

   localparam logic [PTS_W-1:0] PTS_ONE  = 3'd1;
   localparam logic [PTS_W-1:0] PTS_FULL = 3'd4;

   localparam logic [31:0]      GAIN_Q16   = 32'd39797;
   localparam logic [X_W-1:0]   ROUND_HALF = 36'd32768;
   localparam logic [CFG_W-1:0] OCTANT     = 16'h2000;

   localparam logic [CFG_W-1:0] ANGLE_START_RST = 16'd0;
   localparam logic [CFG_W-1:0] ANGLE_STEP_RST  = 16'd182;
   localparam logic [CFG_W-1:0] RANGE_LIMIT_RST = 16'd12000;
   localparam logic [CFG_W-1:0] JOIN_TOL_RST    = 16'd500;
   localparam logic [CFG_W-1:0] DIAMETER_RST    = 16'd300;
   localparam logic [CFG_W-1:0] DIAM_TOL_RST    = 16'd50;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ANGLE_START = 3'd0,
      CSR_ANGLE_STEP  = 3'd1,
      CSR_RANGE_LIMIT = 3'd2,
      CSR_JOIN_TOL    = 3'd3,
      CSR_DIAMETER    = 3'd4,
      CSR_DIAM_TOL    = 3'd5
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ROT,
      ST_ROUND,
      ST_SQ_LOAD,
      ST_SQ_RUN,
      ST_SQ_EVAL,
      ST_SEG_NEW,
      ST_TAIL,
      ST_CLEAR
   } state_type;

   typedef enum logic [1:0] {
      SQ_JOIN,
      SQ_BREAK,
      SQ_LAST
   } sq_mode_type;

   function automatic logic signed [Z_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
      logic signed [Z_W-1:0] val;
      unique case (idx)
         5'd0:    val = 32'sd536870912;
         5'd1:    val = 32'sd316933406;
         5'd2:    val = 32'sd167458907;
         5'd3:    val = 32'sd85004756;
         5'd4:    val = 32'sd42667331;
         5'd5:    val = 32'sd21354465;
         5'd6:    val = 32'sd10679838;
         5'd7:    val = 32'sd5340245;
         5'd8:    val = 32'sd2670163;
         5'd9:    val = 32'sd1335087;
         5'd10:   val = 32'sd667544;
         5'd11:   val = 32'sd333772;
         5'd12:   val = 32'sd166886;
         5'd13:   val = 32'sd83443;
         5'd14:   val = 32'sd41722;
         5'd15:   val = 32'sd20861;
         5'd16:   val = 32'sd10430;
         5'd17:   val = 32'sd5215;
         5'd18:   val = 32'sd2608;
         5'd19:   val = 32'sd1304;
         5'd20:   val = 32'sd652;
         5'd21:   val = 32'sd326;
         5'd22:   val = 32'sd163;
         5'd23:   val = 32'sd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

>>> sv/scan_arc_segment_detector_core.sv
// Scan arc segment detector: range samples to x,y, segment grouping, chord check.
// Depends on sasd_pkg and assert_macros.svh.
// Per word: a skipped sample goes straight to the tail; a usable one passes the serial
// multiply and the shift-add rotation, then opens a segment, or runs a bit-serial squaring
// pass to join one and further passes for a closing check. Words are taken only in idle.
// Synchronous reset loads register defaults and empties the segment; no clearing pass.
`include "assert_macros.svh"

module scan_arc_segment_detector_core #(
   parameter int MAX_SAMPLES = sasd_pkg::MAX_SAMPLES_DEF,
   parameter int TRIG_STEPS  = sasd_pkg::TRIG_STEPS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic        [sasd_pkg::RANGE_W-1:0]     req_range_mm,
   input  logic                                    req_range_invalid,
   input  logic                                    req_last_in_scan,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [sasd_pkg::COORD_W-1:0]     rsp_center_x_mm,
   output logic signed [sasd_pkg::COORD_W-1:0]     rsp_center_y_mm,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic        [sasd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [sasd_pkg::CFG_W-1:0]       csr_data
);

   localparam int IDX_W = $clog2(MAX_SAMPLES);
   localparam int CNT_W = $clog2((TRIG_STEPS > sasd_pkg::SQ_W) ? TRIG_STEPS : sasd_pkg::SQ_W);
   localparam int CW    = sasd_pkg::COORD_W;
   localparam int SW    = sasd_pkg::SQ_W;
   localparam int AW    = sasd_pkg::SQ_ACC_W;
   localparam int XW    = sasd_pkg::X_W;
   localparam int ZW    = sasd_pkg::Z_W;
   localparam int MW    = sasd_pkg::MUL_W;
   localparam int FB    = sasd_pkg::FRAC_BITS;

   sasd_pkg::state_type   state_ff, state_in;
   sasd_pkg::sq_mode_type sq_mode_ff;
   logic [CNT_W-1:0]      cnt_ff;

   logic [sasd_pkg::CFG_W-1:0] ang_start_ff, ang_step_ff, range_limit_ff;
   logic [sasd_pkg::CFG_W-1:0] join_tol_ff, diam_ff, diam_tol_ff;

   logic [IDX_W-1:0]             idx_ff;
   logic                         seg_open_ff;
   logic [sasd_pkg::PTS_W-1:0]   seg_pts_ff;
   logic signed [CW-1:0]         first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;

   logic [MW-1:0]        range_sr_ff, idx_sr_ff, ang_acc_ff;
   logic                 last_ff;
   logic [1:0]           quad_ff;
   logic signed [XW-1:0] x_ff, y_ff;
   logic signed [ZW-1:0] z_ff;
   logic signed [CW-1:0] px_ff, py_ff;

   logic [SW-1:0] sq_sr_ff  [sasd_pkg::LANES];
   logic [SW-1:0] sq_mag_ff [sasd_pkg::LANES];
   logic [AW-1:0] sq_acc_ff [sasd_pkg::LANES];
   logic          lo_en_ff;

   logic                 rsp_valid_ff;
   logic signed [CW-1:0] rsp_x_ff, rsp_y_ff;

   logic                 usable;
   logic                 out_free, out_load, join_take, close_due;
   logic [MW-1:0]        ang_acc_in, turn;
   logic signed [XW-1:0] x_mul_in, sx, sy, x_rnd, y_rnd;
   logic signed [ZW-1:0] z_load, atan_val;
   logic                 z_pos;
   logic signed [CW-1:0] rx, ry, px_in, py_in;
   logic signed [SW-1:0] diff_x, diff_y, mid_x, mid_y;
   logic [SW-1:0]        mag_x, mag_y, c_load, d_load;
   logic [sasd_pkg::CFG_W:0] hi_sum;
   logic [sasd_pkg::CFG_W-1:0] lo_diff;
   logic                 lo_en;
   logic [AW:0]          sq_sum;
   logic                 join_hit, chord_ok;

   // Bit-serial multiplies, MSB first.
   assign ang_acc_in = {ang_acc_ff[MW-2:0], 1'b0} + (idx_sr_ff[MW-1] ? ang_step_ff : '0);
   assign x_mul_in   = $signed({x_ff[XW-2:0], 1'b0})
                       + $signed(range_sr_ff[MW-1] ? XW'(sasd_pkg::GAIN_Q16) : XW'(0));
   assign turn       = ang_acc_in + ang_start_ff + sasd_pkg::OCTANT;
   assign z_load     = {{(ZW-30){~turn[13]}}, ~turn[13], turn[12:0], 16'h0000};

   // Rotation step.
   assign sx       = x_ff >>> cnt_ff;
   assign sy       = y_ff >>> cnt_ff;
   assign atan_val = sasd_pkg::atan_entry(sasd_pkg::ATAN_IDX_W'(cnt_ff));
   assign z_pos    = !z_ff[ZW-1];

   // Rounding and quadrant.
   assign x_rnd = x_ff + $signed(sasd_pkg::ROUND_HALF);
   assign y_rnd = y_ff + $signed(sasd_pkg::ROUND_HALF);
   assign rx    = x_rnd[FB +: CW];
   assign ry    = y_rnd[FB +: CW];

   always_comb begin
      unique case (quad_ff)
         2'd1:    begin px_in = -ry; py_in = rx;  end
         2'd2:    begin px_in = -rx; py_in = -ry; end
         2'd3:    begin px_in = ry;  py_in = -rx; end
         default: begin px_in = rx;  py_in = ry;  end
      endcase
   end

   // Squaring lane operands.
   always_comb begin
      if (sq_mode_ff == sasd_pkg::SQ_JOIN) begin
         diff_x = {px_ff[CW-1], px_ff} - {prev_x_ff[CW-1], prev_x_ff};
         diff_y = {py_ff[CW-1], py_ff} - {prev_y_ff[CW-1], prev_y_ff};
      end else begin
         diff_x = {prev_x_ff[CW-1], prev_x_ff} - {first_x_ff[CW-1], first_x_ff};
         diff_y = {prev_y_ff[CW-1], prev_y_ff} - {first_y_ff[CW-1], first_y_ff};
      end
   end

   assign mag_x   = diff_x[SW-1] ? SW'(-diff_x) : SW'(diff_x);
   assign mag_y   = diff_y[SW-1] ? SW'(-diff_y) : SW'(diff_y);
   assign hi_sum  = {1'b0, diam_ff} + {1'b0, diam_tol_ff};
   assign lo_diff = diam_ff - diam_tol_ff;
   assign lo_en   = diam_ff > diam_tol_ff;
   assign c_load  = (sq_mode_ff == sasd_pkg::SQ_JOIN) ? SW'(join_tol_ff) : SW'(hi_sum);
   assign d_load  = (sq_mode_ff == sasd_pkg::SQ_JOIN || !lo_en) ? '0 : SW'(lo_diff);

   assign sq_sum   = {1'b0, sq_acc_ff[0]} + {1'b0, sq_acc_ff[1]};
   assign join_hit = sq_sum < {1'b0, sq_acc_ff[2]};
   assign chord_ok = (sq_sum <= {1'b0, sq_acc_ff[2]})
                     && (!lo_en_ff || sq_sum >= {1'b0, sq_acc_ff[3]});

   assign mid_x = {first_x_ff[CW-1], first_x_ff} + {prev_x_ff[CW-1], prev_x_ff};
   assign mid_y = {first_y_ff[CW-1], first_y_ff} + {prev_y_ff[CW-1], prev_y_ff};

   assign usable    = !req_range_invalid && (req_range_mm < range_limit_ff);
   assign close_due = last_ff && seg_open_ff && (seg_pts_ff >= sasd_pkg::PTS_FULL);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sasd_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = usable ? sasd_pkg::ST_MUL : sasd_pkg::ST_TAIL;
            end
         end
         sasd_pkg::ST_MUL: begin
            if (cnt_ff == CNT_W'(MW - 1)) begin
               state_in = sasd_pkg::ST_ROT;
            end
         end
         sasd_pkg::ST_ROT: begin
            if (cnt_ff == CNT_W'(TRIG_STEPS - 1)) begin
               state_in = sasd_pkg::ST_ROUND;
            end
         end
         sasd_pkg::ST_ROUND: begin
            state_in = seg_open_ff ? sasd_pkg::ST_SQ_LOAD : sasd_pkg::ST_SEG_NEW;
         end
         sasd_pkg::ST_SQ_LOAD: state_in = sasd_pkg::ST_SQ_RUN;
         sasd_pkg::ST_SQ_RUN: begin
            if (cnt_ff == CNT_W'(SW - 1)) begin
               state_in = sasd_pkg::ST_SQ_EVAL;
            end
         end
         sasd_pkg::ST_SQ_EVAL: begin
            unique case (sq_mode_ff)
               sasd_pkg::SQ_JOIN: begin
                  if (join_hit) begin
                     state_in = sasd_pkg::ST_TAIL;
                  end else if (seg_pts_ff >= sasd_pkg::PTS_FULL) begin
                     state_in = sasd_pkg::ST_SQ_LOAD;
                  end else begin
                     state_in = sasd_pkg::ST_SEG_NEW;
                  end
               end
               sasd_pkg::SQ_BREAK: begin
                  if (!chord_ok || out_free) begin
                     state_in = sasd_pkg::ST_SEG_NEW;
                  end
               end
               default: begin
                  if (!chord_ok || out_free) begin
                     state_in = sasd_pkg::ST_CLEAR;
                  end
               end
            endcase
         end
         sasd_pkg::ST_SEG_NEW: state_in = sasd_pkg::ST_TAIL;
         sasd_pkg::ST_TAIL: begin
            if (close_due) begin
               state_in = sasd_pkg::ST_SQ_LOAD;
            end else if (last_ff) begin
               state_in = sasd_pkg::ST_CLEAR;
            end else begin
               state_in = sasd_pkg::ST_IDLE;
            end
         end
         sasd_pkg::ST_CLEAR: state_in = sasd_pkg::ST_IDLE;
         default:            state_in = sasd_pkg::ST_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      req_ready = (state_ff == sasd_pkg::ST_IDLE);
      out_free  = !rsp_valid_ff || rsp_ready;
      out_load  = (state_ff == sasd_pkg::ST_SQ_EVAL) && (sq_mode_ff != sasd_pkg::SQ_JOIN)
                  && chord_ok && out_free;
      join_take = (state_ff == sasd_pkg::ST_SQ_EVAL) && (sq_mode_ff == sasd_pkg::SQ_JOIN)
                  && join_hit;
   end

   assign csr_ready       = 1'b1;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_center_x_mm = rsp_x_ff;
   assign rsp_center_y_mm = rsp_y_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= sasd_pkg::ST_IDLE;
         cnt_ff         <= '0;
         sq_mode_ff     <= sasd_pkg::SQ_JOIN;
         ang_start_ff   <= sasd_pkg::ANGLE_START_RST;
         ang_step_ff    <= sasd_pkg::ANGLE_STEP_RST;
         range_limit_ff <= sasd_pkg::RANGE_LIMIT_RST;
         join_tol_ff    <= sasd_pkg::JOIN_TOL_RST;
         diam_ff        <= sasd_pkg::DIAMETER_RST;
         diam_tol_ff    <= sasd_pkg::DIAM_TOL_RST;
         idx_ff         <= '0;
         seg_open_ff    <= 1'b0;
         seg_pts_ff     <= '0;
         first_x_ff     <= '0;
         first_y_ff     <= '0;
         prev_x_ff      <= '0;
         prev_y_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= (state_in != state_ff) ? '0 : cnt_ff + 1'b1;

         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               sasd_pkg::CSR_ANGLE_START: ang_start_ff   <= csr_data;
               sasd_pkg::CSR_ANGLE_STEP:  ang_step_ff    <= csr_data;
               sasd_pkg::CSR_RANGE_LIMIT: range_limit_ff <= csr_data;
               sasd_pkg::CSR_JOIN_TOL:    join_tol_ff    <= csr_data;
               sasd_pkg::CSR_DIAMETER:    diam_ff        <= csr_data;
               sasd_pkg::CSR_DIAM_TOL:    diam_tol_ff    <= csr_data;
               default: ;
            endcase
         end

         unique case (state_ff)
            sasd_pkg::ST_ROUND:   sq_mode_ff <= sasd_pkg::SQ_JOIN;
            sasd_pkg::ST_SQ_EVAL: begin
               if (sq_mode_ff == sasd_pkg::SQ_JOIN) begin
                  sq_mode_ff <= sasd_pkg::SQ_BREAK;
               end
            end
            sasd_pkg::ST_TAIL:    sq_mode_ff <= sasd_pkg::SQ_LAST;
            default: ;
         endcase

         if (join_take) begin
            prev_x_ff <= px_ff;
            prev_y_ff <= py_ff;
            if (seg_pts_ff < sasd_pkg::PTS_FULL) begin
               seg_pts_ff <= seg_pts_ff + 1'b1;
            end
         end

         if (state_ff == sasd_pkg::ST_SEG_NEW) begin
            seg_open_ff <= 1'b1;
            seg_pts_ff  <= sasd_pkg::PTS_ONE;
            first_x_ff  <= px_ff;
            first_y_ff  <= py_ff;
            prev_x_ff   <= px_ff;
            prev_y_ff   <= py_ff;
         end

         if (state_ff == sasd_pkg::ST_CLEAR) begin
            seg_open_ff <= 1'b0;
            seg_pts_ff  <= '0;
            first_x_ff  <= '0;
            first_y_ff  <= '0;
            prev_x_ff   <= '0;
            prev_y_ff   <= '0;
         end

         if (state_ff == sasd_pkg::ST_TAIL) begin
            if (last_ff || idx_ff == IDX_W'(MAX_SAMPLES - 1)) begin
               idx_ff <= '0;
            end else begin
               idx_ff <= idx_ff + 1'b1;
            end
         end

         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      unique case (state_ff)
         sasd_pkg::ST_IDLE: begin
            range_sr_ff <= req_range_mm;
            idx_sr_ff   <= MW'(idx_ff);
            last_ff     <= req_last_in_scan;
            ang_acc_ff  <= '0;
            x_ff        <= '0;
         end
         sasd_pkg::ST_MUL: begin
            range_sr_ff <= {range_sr_ff[MW-2:0], 1'b0};
            idx_sr_ff   <= {idx_sr_ff[MW-2:0], 1'b0};
            ang_acc_ff  <= ang_acc_in;
            x_ff        <= x_mul_in;
            y_ff        <= '0;
            z_ff        <= z_load;
            quad_ff     <= turn[MW-1:MW-2];
         end
         sasd_pkg::ST_ROT: begin
            if (z_pos) begin
               x_ff <= x_ff - sy;
               y_ff <= y_ff + sx;
               z_ff <= z_ff - atan_val;
            end else begin
               x_ff <= x_ff + sy;
               y_ff <= y_ff - sx;
               z_ff <= z_ff + atan_val;
            end
         end
         sasd_pkg::ST_ROUND: begin
            px_ff <= px_in;
            py_ff <= py_in;
         end
         sasd_pkg::ST_SQ_LOAD: begin
            sq_sr_ff[0]  <= mag_x;
            sq_sr_ff[1]  <= mag_y;
            sq_sr_ff[2]  <= c_load;
            sq_sr_ff[3]  <= d_load;
            sq_mag_ff[0] <= mag_x;
            sq_mag_ff[1] <= mag_y;
            sq_mag_ff[2] <= c_load;
            sq_mag_ff[3] <= d_load;
            lo_en_ff     <= (sq_mode_ff != sasd_pkg::SQ_JOIN) && lo_en;
            for (int i = 0; i < sasd_pkg::LANES; i++) begin
               sq_acc_ff[i] <= '0;
            end
         end
         sasd_pkg::ST_SQ_RUN: begin
            for (int i = 0; i < sasd_pkg::LANES; i++) begin
               sq_acc_ff[i] <= {sq_acc_ff[i][AW-2:0], 1'b0}
                               + (sq_sr_ff[i][SW-1] ? AW'(sq_mag_ff[i]) : AW'(0));
               sq_sr_ff[i]  <= {sq_sr_ff[i][SW-2:0], 1'b0};
            end
         end
         default: ;
      endcase

      if (out_load) begin
         rsp_x_ff <= mid_x[SW-1:1];
         rsp_y_ff <= mid_y[SW-1:1];
      end
   end

   `ASSERT_IMPLY(a_open_points, clock, reset, seg_open_ff, (seg_pts_ff >= sasd_pkg::PTS_ONE && seg_pts_ff <= sasd_pkg::PTS_FULL))
   `ASSERT_IMPLY(a_closed_empty, clock, reset, !seg_open_ff, seg_pts_ff == '0)
   `ASSERT_IMPLY(a_result_from_close, clock, reset, out_load, (sq_mode_ff != sasd_pkg::SQ_JOIN && !rsp_valid_ff || out_load && rsp_ready))
   `ASSERT_NEXT(a_scan_restart, clock, reset, (state_ff == sasd_pkg::ST_TAIL && last_ff), idx_ff == '0)

endmodule

>>> tb/sv/sasd_center_checker.sv
// Scoreboard for the scan arc segment detector: mirrors the register bank and the
// segment state, predicts every center word and compares it on the rsp channel.
// Depends on sasd_pkg.
module sasd_center_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic [sasd_pkg::RANGE_W-1:0]        req_range_mm,
   input  logic                                req_range_invalid,
   input  logic                                req_last_in_scan,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [sasd_pkg::COORD_W-1:0] rsp_center_x_mm,
   input  logic signed [sasd_pkg::COORD_W-1:0] rsp_center_y_mm,
   input  logic                                csr_valid,
   input  logic                                csr_ready,
   input  sasd_pkg::csr_index_type             csr_index,
   input  logic [sasd_pkg::CFG_W-1:0]          csr_data,
   output int                                  mismatch_count,
   output int                                  centers_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import sasd_pkg::*;

   localparam longint ROT_GAIN = 39797;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } center_word_t;

   logic [CFG_W-1:0] angle_start, angle_step, range_limit;
   logic [CFG_W-1:0] join_tol, diameter, diam_tol;
   int unsigned      beam_index;
   bit               seg_open;
   int               seg_points;
   longint           first_x, first_y, prev_x, prev_y;
   center_word_t     center_q[$];
   center_word_t     want;

   // atan(2^-i) in units of 2^-32 turn
   function automatic longint arc_angle(input int i);
      case (i)
         0:       return 536870912;
         1:       return 316933406;
         2:       return 167458907;
         3:       return 85004756;
         4:       return 42667331;
         5:       return 21354465;
         6:       return 10679838;
         7:       return 5340245;
         8:       return 2670163;
         9:       return 1335087;
         10:      return 667544;
         11:      return 333772;
         12:      return 166886;
         13:      return 83443;
         14:      return 41722;
         15:      return 20861;
         16:      return 10430;
         17:      return 5215;
         18:      return 2608;
         19:      return 1304;
         20:      return 652;
         21:      return 326;
         22:      return 163;
         23:      return 81;
         default: return 0;
      endcase
   endfunction

   function automatic void beam_to_xy(input logic [RANGE_W-1:0] r, input logic [CFG_W-1:0] ang,
                                      output longint px, output longint py);
      logic [CFG_W-1:0] t;
      longint x, y, z, sx, sy, rx, ry;
      int i;
      t = ang + OCTANT;
      z = (longint'(t[13:0]) - 8192) * 65536;
      x = longint'(r) * ROT_GAIN;
      y = 0;
      for (i = 0; i < TRIG_STEPS_DEF; i++) begin
         sx = x >>> i;
         sy = y >>> i;
         if (z >= 0) begin
            x = x - sy;
            y = y + sx;
            z = z - arc_angle(i);
         end else begin
            x = x + sy;
            y = y - sx;
            z = z + arc_angle(i);
         end
      end
      rx = (x + 32768) >>> 16;
      ry = (y + 32768) >>> 16;
      case (t[15:14])
         2'd1: begin
            px = -ry;
            py = rx;
         end
         2'd2: begin
            px = -rx;
            py = -ry;
         end
         2'd3: begin
            px = ry;
            py = -rx;
         end
         default: begin
            px = rx;
            py = ry;
         end
      endcase
   endfunction

   function automatic bit chord_center(output center_word_t c);
      longint dx, dy, d2, hi, lo, mid;
      c = '0;
      if (!seg_open || seg_points < 4)
         return 1'b0;
      dx = prev_x - first_x;
      dy = prev_y - first_y;
      d2 = dx * dx + dy * dy;
      hi = longint'(diameter) + longint'(diam_tol);
      if (d2 > hi * hi)
         return 1'b0;
      if (diameter > diam_tol) begin
         lo = longint'(diameter) - longint'(diam_tol);
         if (d2 < lo * lo)
            return 1'b0;
      end
      mid = (first_x + prev_x) >>> 1;
      c.x = mid[COORD_W-1:0];
      mid = (first_y + prev_y) >>> 1;
      c.y = mid[COORD_W-1:0];
      return 1'b1;
   endfunction

   task automatic clear_scan();
      seg_open   = 1'b0;
      seg_points = 0;
      first_x    = 0;
      first_y    = 0;
      prev_x     = 0;
      prev_y     = 0;
      beam_index = 0;
   endtask

   task automatic take_beam(input logic [RANGE_W-1:0] r, input logic inv, input logic lst);
      longint px, py, dx, dy, tol;
      center_word_t c;
      bit hit;
      hit = 1'b0;
      c   = '0;
      if (!inv && r < range_limit) begin
         beam_to_xy(r, angle_start + angle_step * beam_index[CFG_W-1:0], px, py);
         dx  = px - prev_x;
         dy  = py - prev_y;
         tol = longint'(join_tol);
         if (seg_open && dx * dx + dy * dy < tol * tol) begin
            if (seg_points < 4)
               seg_points++;
            prev_x = px;
            prev_y = py;
         end else begin
            if (seg_open)
               hit = chord_center(c);
            seg_open   = 1'b1;
            seg_points = 1;
            first_x    = px;
            first_y    = py;
            prev_x     = px;
            prev_y     = py;
         end
      end
      beam_index = (beam_index + 1 >= MAX_SAMPLES_DEF) ? 0 : beam_index + 1;
      if (lst) begin
         if (!hit)
            hit = chord_center(c);
         clear_scan();
      end
      if (hit)
         center_q.push_back(c);
   endtask

   task automatic flag(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s", $time, msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         angle_start = ANGLE_START_RST;
         angle_step  = ANGLE_STEP_RST;
         range_limit = RANGE_LIMIT_RST;
         join_tol    = JOIN_TOL_RST;
         diameter    = DIAMETER_RST;
         diam_tol    = DIAM_TOL_RST;
         clear_scan();
         center_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (center_q.size() == 0) begin
               flag($sformatf("center word (%0d, %0d) with none expected",
                              rsp_center_x_mm, rsp_center_y_mm));
            end else begin
               want = center_q.pop_front();
               if (rsp_center_x_mm !== want.x)
                  flag($sformatf("center_x_mm expected %0d, got %0d",
                                 $signed(want.x), rsp_center_x_mm));
               if (rsp_center_y_mm !== want.y)
                  flag($sformatf("center_y_mm expected %0d, got %0d",
                                 $signed(want.y), rsp_center_y_mm));
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ANGLE_START: angle_start = csr_data;
               CSR_ANGLE_STEP:  angle_step  = csr_data;
               CSR_RANGE_LIMIT: range_limit = csr_data;
               CSR_JOIN_TOL:    join_tol    = csr_data;
               CSR_DIAMETER:    diameter    = csr_data;
               CSR_DIAM_TOL:    diam_tol    = csr_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            take_beam(req_range_mm, req_range_invalid, req_last_in_scan);
      end
      centers_pending = center_q.size();
   end

endmodule

>>> tb/sv/tb_top.sv
// Top of the scan arc segment detector testbench: clock, reset, register setups,
// directed and random range scans with random idling, and the final verdict.
// Depends on sasd_pkg, sasd_center_checker and scan_arc_segment_detector_core.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sasd_pkg::*;

   localparam int HALF_PERIOD  = 5;
   localparam int CORE_LATENCY = 100;
   localparam int DRAIN_LIMIT  = 5000;
   localparam int RUN_LIMIT    = 2000000;

   logic                      clock             = 1'b0;
   logic                      reset             = 1'b1;
   logic                      req_valid         = 1'b0;
   logic                      req_ready;
   logic [RANGE_W-1:0]        req_range_mm      = '0;
   logic                      req_range_invalid = 1'b0;
   logic                      req_last_in_scan  = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready         = 1'b0;
   logic signed [COORD_W-1:0] rsp_center_x_mm;
   logic signed [COORD_W-1:0] rsp_center_y_mm;
   logic                      csr_valid         = 1'b0;
   logic                      csr_ready;
   csr_index_type             csr_index         = CSR_ANGLE_START;
   logic [CFG_W-1:0]          csr_data          = '0;

   int mismatch_count;
   int centers_pending;
   int idle_pct = 8;
   int cur_step;
   int cur_limit;
   int cur_diam;
   int usable_sent;
   int total_sent;
   int cycle_count = 0;

   scan_arc_segment_detector_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_range_mm      (req_range_mm),
      .req_range_invalid (req_range_invalid),
      .req_last_in_scan  (req_last_in_scan),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_center_x_mm   (rsp_center_x_mm),
      .rsp_center_y_mm   (rsp_center_y_mm),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   sasd_center_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_range_mm      (req_range_mm),
      .req_range_invalid (req_range_invalid),
      .req_last_in_scan  (req_last_in_scan),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_center_x_mm   (rsp_center_x_mm),
      .rsp_center_y_mm   (rsp_center_y_mm),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .mismatch_count    (mismatch_count),
      .centers_pending   (centers_pending)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_sample(input int r, input bit inv, input bit lst);
      logic [RANGE_W-1:0] rr;
      rr = r[RANGE_W-1:0];
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_range_mm      <= rr;
      req_range_invalid <= inv;
      req_last_in_scan  <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      total_sent++;
      if (!inv && int'(rr) < cur_limit)
         usable_sent++;
   endtask

   // no-hit word: either flagged invalid or at or beyond the range limit
   task automatic send_filler(input bit lst);
      if (cur_limit >= 65535 || $urandom_range(1) == 0)
         send_sample($urandom_range(0, 65535), 1'b1, lst);
      else
         send_sample($urandom_range(cur_limit, 65535), 1'b0, lst);
   endtask

   // k beams at roughly constant range, optional invalid beam before point hole
   task automatic send_arc(input int r, input int k, input int hole, input bit lst);
      int i, rj;
      for (i = 0; i < k; i++) begin
         if (i == hole)
            send_sample($urandom_range(0, 65535), 1'b1, 1'b0);
         rj = r + int'($urandom_range(0, 6)) - 3;
         send_sample(rj, 1'b0, lst && i == k - 1);
      end
   endtask

   task automatic write_reg(input csr_index_type idx, input int val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val[CFG_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic settle();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (centers_pending != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (CORE_LATENCY) @(negedge clock);
   endtask

   task automatic apply_setting(input int start, input int step, input int limit,
                                input int join_mm, input int diam, input int tol);
      settle();
      write_reg(CSR_ANGLE_START, start);
      write_reg(CSR_ANGLE_STEP, step);
      write_reg(CSR_RANGE_LIMIT, limit);
      write_reg(CSR_JOIN_TOL, join_mm);
      write_reg(CSR_DIAMETER, diam);
      write_reg(CSR_DIAM_TOL, tol);
      csr_valid <= 1'b0;
      cur_step  = step;
      cur_limit = limit;
      cur_diam  = diam;
   endtask

   // mostly whole scans of arcs sized near the target chord, the rest noise
   task automatic run_random(input int budget);
      int     k, hole, stp, arcs, a, r;
      bit     end_on_arc;
      longint rad;
      usable_sent = 0;
      total_sent  = 0;
      stp = (cur_step < 0) ? -cur_step : cur_step;
      if (stp == 0)
         stp = 1;
      while (usable_sent < budget && total_sent < 6 * budget) begin
         if ($urandom_range(3) == 0) begin
            r = int'($urandom_range(0, 65535));
            if ($urandom_range(4) == 0)
               r = cur_limit - 1 + int'($urandom_range(0, 2));
            send_sample(r, ($urandom_range(3) == 0), ($urandom_range(15) == 0));
         end else begin
            arcs       = $urandom_range(1, 3);
            end_on_arc = $urandom_range(1);
            for (a = 0; a < arcs; a++) begin
               repeat ($urandom_range(0, 3)) send_filler(1'b0);
               k = ($urandom_range(5) == 0) ? $urandom_range(2, 3) : $urandom_range(4, 9);
               rad = longint'(cur_diam) * 10430 * longint'($urandom_range(85, 115))
                     / (100 * longint'(k - 1) * longint'(stp));
               if (rad > cur_limit - 8)
                  rad = cur_limit - 8;
               if (rad < 8)
                  rad = 8;
               hole = ($urandom_range(3) == 0) ? int'($urandom_range(1, k - 1)) : -1;
               send_arc(int'(rad), k, hole, end_on_arc && a == arcs - 1);
            end
            if (!end_on_arc)
               send_filler(1'b1);
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      apply_setting(ANGLE_START_RST, ANGLE_STEP_RST, RANGE_LIMIT_RST,
                    JOIN_TOL_RST, DIAMETER_RST, DIAM_TOL_RST);
      send_sample(0, 1'b0, 1'b1);
      send_sample(65535, 1'b0, 1'b0);
      send_sample(cur_limit, 1'b0, 1'b0);
      send_sample(200, 1'b1, 1'b0);
      send_arc(3438, 5, 2, 1'b0);
      send_arc(800, 4, -1, 1'b1);
      send_arc(10000, 4, -1, 1'b0);
      send_sample(cur_limit - 1, 1'b0, 1'b1);

      // run the beam index across its wrap inside one scan
      repeat (MAX_SAMPLES_DEF - 4) send_filler(1'b0);
      send_arc(2000, 8, -1, 1'b1);

      run_random(90);

      apply_setting(-32768, 32767, 65535, 65535, 65535, 65535);
      run_random(80);

      apply_setting(32767, -32768, 0, 1, 0, 0);
      run_random(30);

      idle_pct = 0;
      apply_setting($urandom_range(0, 65535), 364, 8000, 300, 500, 100);
      run_random(90);
      idle_pct = 8;

      apply_setting(16384, -182, 20000, 800, 200, 200);
      run_random(80);

      apply_setting(-8192, 91, 65535, 0, 1000, 0);
      run_random(60);

      apply_setting(0, 182, 12000, 500, $urandom_range(100, 600), $urandom_range(0, 120));
      run_random(80);

      settle();
      if (mismatch_count == 0 && centers_pending == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/sasd_pkg.sv
sv/scan_arc_segment_detector_core.sv
tb/sv/sasd_center_checker.sv
tb/sv/tb_top.sv
